// ===== rtl/core/vdch_pkg.sv =====
// ----------------------------------------------------------------------------
// vdch_pkg
// Shared types, register indexes and helpers for the drive command handler.
// ----------------------------------------------------------------------------
package vdch_pkg;

  // Wide enough for every signed intermediate of the pulse arithmetic.
  localparam int SumW = 15;
  localparam int PulseW = 12;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 12;

  localparam logic [PulseW-1:0] PulseMax = PulseW'(4095);
  localparam logic signed [SumW-1:0] TrimStep = SumW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    REG_NEUTRAL_PULSE    = 3'd0,
    REG_MAX_STEER_OFFSET = 3'd1,
    REG_PEAK_MARGIN      = 3'd2,
    REG_FORWARD_START    = 3'd3,
    REG_FORWARD_RANGE    = 3'd4,
    REG_BACKWARD_START   = 3'd5,
    REG_BACKWARD_RANGE   = 3'd6,
    REG_ACCEL_LIMIT      = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] steer_x;
    logic signed [15:0] throttle_y;
    logic               obstacle;
    logic               press_auto;
    logic               press_right_signal;
    logic               press_left_signal;
    logic               press_cruise;
    logic               press_trim_up;
    logic               press_trim_down;
  } cmd_t;

  typedef struct packed {
    logic [11:0] motor_pulse;
    logic [11:0] steer_pulse;
    logic        left_signal_on;
    logic        right_signal_on;
    logic        auto_mode;
    logic        cruise_on;
  } result_t;

  typedef struct packed {
    logic [11:0] neutral_pulse;
    logic [9:0]  max_steer_offset;
    logic [9:0]  peak_margin;
    logic [11:0] forward_start;
    logic [9:0]  forward_range;
    logic [11:0] backward_start;
    logic [9:0]  backward_range;
    logic [7:0]  accel_limit;
  } cfg_t;

  typedef struct packed {
    logic        auto_flag;
    logic        cruise_flag;
    logic        left_active;
    logic        right_active;
    logic        peak_seen;
    logic [11:0] last_request;
    logic [11:0] motor_value;
    logic [11:0] steer_value;
  } state_t;

  // Clamp a signed intermediate to the pulse range.
  function automatic logic [PulseW-1:0] sat_pulse(input logic signed [SumW-1:0] v);
    logic [PulseW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({{(SumW-PulseW){1'b0}}, PulseMax})) begin
      r = PulseMax;
    end else begin
      r = v[PulseW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/vdch_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// vdch_cfg_regs
// Configuration register bank written through a plain write port.
// ----------------------------------------------------------------------------
module vdch_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [vdch_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [vdch_pkg::CfgDataW-1:0]  cfg_wdata,
  output vdch_pkg::cfg_t                 cfg
);

  vdch_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.neutral_pulse    <= 12'd1550;
      cfg_r.max_steer_offset <= 10'd270;
      cfg_r.peak_margin      <= 10'd75;
      cfg_r.forward_start    <= 12'd1618;
      cfg_r.forward_range    <= 10'd27;
      cfg_r.backward_start   <= 12'd1490;
      cfg_r.backward_range   <= 10'd100;
      cfg_r.accel_limit      <= 8'd1;
    end else if (cfg_we) begin
      unique case (vdch_pkg::cfg_reg_e'(cfg_index))
        vdch_pkg::REG_NEUTRAL_PULSE:    cfg_r.neutral_pulse    <= cfg_wdata;
        vdch_pkg::REG_MAX_STEER_OFFSET: cfg_r.max_steer_offset <= cfg_wdata[9:0];
        vdch_pkg::REG_PEAK_MARGIN:      cfg_r.peak_margin      <= cfg_wdata[9:0];
        vdch_pkg::REG_FORWARD_START:    cfg_r.forward_start    <= cfg_wdata;
        vdch_pkg::REG_FORWARD_RANGE:    cfg_r.forward_range    <= cfg_wdata[9:0];
        vdch_pkg::REG_BACKWARD_START:   cfg_r.backward_start   <= cfg_wdata;
        vdch_pkg::REG_BACKWARD_RANGE:   cfg_r.backward_range   <= cfg_wdata[9:0];
        vdch_pkg::REG_ACCEL_LIMIT:      cfg_r.accel_limit      <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/vdch_step.sv =====
// ----------------------------------------------------------------------------
// vdch_step
// Next-state logic for one drive command: steering, motor, signals, trim.
// ----------------------------------------------------------------------------
module vdch_step (
  input  vdch_pkg::cmd_t   cmd,
  input  vdch_pkg::cfg_t   cfg,
  input  vdch_pkg::state_t st,
  output vdch_pkg::state_t st_nxt
);

  logic signed [26:0]               steer_prod;
  logic signed [11:0]               steer_off;
  logic signed [vdch_pkg::SumW-1:0] ctr_s;
  logic signed [vdch_pkg::SumW-1:0] steer_s;
  logic signed [vdch_pkg::SumW-1:0] thr_s;
  logic [11:0]                      steer_new;
  logic                             ty_neg;
  logic                             ty_pos;
  logic [15:0]                      ty_mag;
  logic [9:0]                       band_range;
  logic [25:0]                      thr_prod;
  logic signed [vdch_pkg::SumW-1:0] req_raw;
  logic signed [vdch_pkg::SumW-1:0] req_s;
  logic signed [vdch_pkg::SumW-1:0] last_s;
  logic signed [vdch_pkg::SumW-1:0] acc_s;
  logic signed [vdch_pkg::SumW-1:0] fs_s;
  logic signed [vdch_pkg::SumW-1:0] bs_s;
  logic signed [vdch_pkg::SumW-1:0] motor_s;
  logic                             cruise_now;
  logic                             left_now;
  logic                             right_now;

  // Steering map, floor of the Q1.15 product by taking the top bits.
  always_comb begin
    steer_prod = cmd.steer_x * $signed({1'b0, cfg.max_steer_offset});
    steer_off  = steer_prod[26:15];
    ctr_s      = {3'b000, cfg.neutral_pulse};
    steer_s    = ctr_s + {{3{steer_off[11]}}, steer_off};
    steer_new  = vdch_pkg::sat_pulse(steer_s);
    thr_s      = {5'b00000, cfg.peak_margin};
  end

  // Throttle magnitude through one shared multiplier.
  always_comb begin
    ty_neg     = cmd.throttle_y[15];
    ty_pos     = !ty_neg && (cmd.throttle_y != 16'sd0);
    ty_mag     = ty_neg ? (~cmd.throttle_y + 16'd1) : cmd.throttle_y;
    band_range = ty_neg ? cfg.backward_range : cfg.forward_range;
    thr_prod   = ty_mag * band_range;
    req_raw    = {4'b0000, thr_prod[25:15]};
    last_s     = {3'b000, st.last_request};
    acc_s      = {7'b0000000, cfg.accel_limit};
    fs_s       = {3'b000, cfg.forward_start};
    bs_s       = {3'b000, cfg.backward_start};
  end

  always_comb begin
    st_nxt     = st;
    cruise_now = st.cruise_flag;
    left_now   = st.left_active;
    right_now  = st.right_active;
    motor_s    = '0;
    req_s      = req_raw;

    st_nxt.auto_flag = st.auto_flag ^ cmd.press_auto;

    if (!st_nxt.auto_flag) begin
      st_nxt.steer_value = steer_new;

      // Reverse stick drops cruise hold first.
      if (ty_neg) begin
        cruise_now = 1'b0;
      end

      if (!cruise_now) begin
        if (ty_pos && !cmd.obstacle) begin
          if (req_s - last_s > acc_s) begin
            req_s = last_s + acc_s;
          end
          st_nxt.motor_value = vdch_pkg::sat_pulse(fs_s + req_s);
        end else if (ty_neg) begin
          if (last_s - req_s > acc_s) begin
            req_s = last_s - acc_s;
          end
          st_nxt.motor_value = vdch_pkg::sat_pulse(bs_s - req_s);
        end else begin
          req_s              = '0;
          st_nxt.motor_value = cfg.neutral_pulse;
        end
        st_nxt.last_request = vdch_pkg::sat_pulse(req_s);
      end

      // Right press first, then left.
      if (cmd.press_right_signal) begin
        right_now = !right_now;
        left_now  = 1'b0;
      end
      if (cmd.press_left_signal) begin
        left_now  = !left_now;
        right_now = 1'b0;
      end

      // Auto-cancel once the turn peaked and the wheel is back at center.
      if (left_now || right_now) begin
        if (st.peak_seen) begin
          if (steer_new == cfg.neutral_pulse) begin
            left_now         = 1'b0;
            right_now        = 1'b0;
            st_nxt.peak_seen = 1'b0;
          end
        end else if (left_now) begin
          if ($signed({3'b000, steer_new}) < ctr_s - thr_s) begin
            st_nxt.peak_seen = 1'b1;
          end
        end else begin
          if ($signed({3'b000, steer_new}) > ctr_s + thr_s) begin
            st_nxt.peak_seen = 1'b1;
          end
        end
      end

      st_nxt.left_active  = left_now;
      st_nxt.right_active = right_now;
      st_nxt.cruise_flag  = cruise_now ^ cmd.press_cruise;

      // Trim up wins over trim down.
      motor_s = {3'b000, st_nxt.motor_value};
      if (cmd.press_trim_up) begin
        st_nxt.motor_value = vdch_pkg::sat_pulse(motor_s + vdch_pkg::TrimStep);
      end else if (cmd.press_trim_down) begin
        st_nxt.motor_value = vdch_pkg::sat_pulse(motor_s - vdch_pkg::TrimStep);
      end
    end
  end

endmodule

// ===== rtl/core/vehicle_drive_command_handler_top.sv =====
// ----------------------------------------------------------------------------
// vehicle_drive_command_handler_top
// Drive command handler: one controller request in, one pulse/status result out.
// ----------------------------------------------------------------------------
// Each accepted request is one controller command (Q1.15 steering and
// throttle sticks, obstacle flag, six button presses). It lands in an input
// register; the step logic then evaluates it against the held drive state
// (mode flags, turn signals, last throttle request, motor and steering
// pulses), and once the result slot is free or being drained the result
// register captures the updated pulses and flags while the state registers
// take the new state. The result then shows valid and can be taken at the
// next edge, and one request is taken every cycle as long as results are
// drained; the rate is set by the single state update per cycle, whose
// longest path is the throttle multiply followed by the slew-limit compare
// and pulse saturation. While a finished result waits at the output the input
// register takes one more request, then in_ready drops until the result
// drains. Configuration registers are written with cfg_we/cfg_index/cfg_wdata
// and should only change while no request is in flight.
// ----------------------------------------------------------------------------
module vehicle_drive_command_handler_top (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  vdch_pkg::cmd_t                in_data,

  output logic                          out_valid,
  input  logic                          out_ready,
  output vdch_pkg::result_t             out_data,

  input  logic                          cfg_we,
  input  logic [vdch_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [vdch_pkg::CfgDataW-1:0] cfg_wdata
);

  vdch_pkg::cfg_t    cfg;
  logic              in_v_r;
  vdch_pkg::cmd_t    in_data_r;
  vdch_pkg::state_t  st_r;
  vdch_pkg::state_t  st_nxt;
  logic              out_v_r;
  vdch_pkg::result_t out_data_r;
  vdch_pkg::result_t res_nxt;
  logic              advance;

  vdch_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  vdch_step u_step (
    .cmd    (in_data_r),
    .cfg    (cfg),
    .st     (st_r),
    .st_nxt (st_nxt)
  );

  // Advance the held request when the result slot is free or being drained.
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  // Payload holds while the request waits.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data_r <= in_data;
    end
  end

  // Drive state moves only when a request is evaluated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result reflects the state after the command.
  always_comb begin
    res_nxt.motor_pulse     = st_nxt.motor_value;
    res_nxt.steer_pulse     = st_nxt.steer_value;
    res_nxt.left_signal_on  = st_nxt.left_active;
    res_nxt.right_signal_on = st_nxt.right_active;
    res_nxt.auto_mode       = st_nxt.auto_flag;
    res_nxt.cruise_on       = st_nxt.cruise_flag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_data_r;

endmodule
